// File: src/rgb8m_pkg.sv
// ----------------------------------------------------------------------------
// rgb8m_pkg: shared types and constants
// Word layouts, register codes and sizes used by the eight-neighbour mean.
// ----------------------------------------------------------------------------
`default_nettype none

package rgb8m_pkg;

    localparam int MAX_WIDTH_DEF = 2048;  // longest row the line stores hold
    localparam int QDEPTH_DEF    = 4;     // front to back queue
    localparam int ODEPTH_DEF    = 2;     // result queue

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [15:0] out_row;
        logic [10:0] out_col;
        logic        frame_last;
    } result_t;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // eight neighbours of one interior pixel plus its position
    typedef struct packed {
        pixel_t [7:0] nb;
        logic [15:0]  row;
        logic [10:0]  col;
        logic         last;
    } window_word_t;

endpackage

`default_nettype wire

// File: src/rgb8m_ram.sv
// ----------------------------------------------------------------------------
// rgb8m_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb8m_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/rgb8m_fifo.sv
// ----------------------------------------------------------------------------
// rgb8m_fifo: small flop queue
// First-word-fall-through queue with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb8m_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           rdata,
    output logic                            empty,
    output logic                            full,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == CW'(0));
    assign full    = (count_reg == CW'(DEPTH));
    assign count   = count_reg;
    assign rdata   = data_reg[head_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == AW'(DEPTH - 1)) ? AW'(0) : tail_reg + AW'(1);
        end
        if (do_pop)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? AW'(0) : head_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[tail_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: src/rgb8m_front.sv
// ----------------------------------------------------------------------------
// rgb8m_front: raster position, line stores and window
// Accepts pixels, tracks row and column, builds the 3x3 window and queues
// one neighbour word for every interior pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb8m_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int QDEPTH    = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rgb8m_pkg::cfg_wr_t            cfg,
    input  wire logic                          push,
    input  wire rgb8m_pkg::pixel_t             pixel,
    output logic                               full,
    output logic                               q_push,
    output rgb8m_pkg::window_word_t            q_word,
    input  wire logic [$clog2(QDEPTH+1)-1:0]   q_count
);

    import rgb8m_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = (CW + 1 > 12) ? CW + 1 : 12;
    localparam int QCW = $clog2(QDEPTH + 1);

    logic [11:0]   width_reg, width_next;
    logic [15:0]   height_reg, height_next;
    logic [CW-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;

    // stage 1: pixel waiting for its line store read
    logic          s1_valid_reg;
    pixel_t        s1_pix_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_emit_reg;
    logic [15:0]   s1_row_o_reg;
    logic [10:0]   s1_col_o_reg;
    logic          s1_last_reg;

    pixel_t        win_reg [3][3];
    logic [47:0]   ls_rdata;
    pixel_t        top, mid;

    logic          accept;
    logic [WW-1:0] w_ext, eff_w, col_inc, col_ext;
    logic [15:0]   eff_h;
    logic [16:0]   row_inc;
    logic          col_wrap;
    logic [QCW:0]  need;

    assign need   = {1'b0, q_count} + {{QCW{1'b0}}, s1_valid_reg};
    assign full   = (need >= (QCW + 1)'(QDEPTH));
    assign accept = push && !full;

    always_comb
    begin
        w_ext    = WW'(width_reg);
        eff_w    = (w_ext < WW'(3)) ? WW'(3)
                 : ((w_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_ext);
        eff_h    = (height_reg < 16'd3) ? 16'd3 : height_reg;
        col_ext  = WW'(col_reg);
        col_inc  = col_ext + WW'(1);
        row_inc  = {1'b0, row_reg} + 17'd1;
        col_wrap = (col_inc >= eff_w);
    end

    // position and registers
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = (row_inc >= {1'b0, eff_h}) ? 16'd0 : row_inc[15:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
        if (cfg.en)
        begin
            unique case (cfg.index)
                CFG_IMAGE_WIDTH:
                begin
                    width_next = cfg.data[11:0];
                    col_next   = '0;
                    row_next   = '0;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_next = cfg.data;
                    col_next    = '0;
                    row_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pixel;
            s1_col_reg   <= col_reg;
            s1_emit_reg  <= (row_reg >= 16'd2) && (col_reg >= CW'(2));
            s1_row_o_reg <= row_reg - 16'd1;
            s1_col_o_reg <= 11'(col_ext - WW'(1));
            s1_last_reg  <= (row_inc >= {1'b0, eff_h}) && col_wrap;
        end
    end

    // line stores packed as {two rows up, one row up}
    rgb8m_ram #(
        .WIDTH (48),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata ({mid, s1_pix_reg}),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ls_rdata)
    );

    assign top = ls_rdata[47:24];
    assign mid = ls_rdata[23:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top;
            win_reg[1][2] <= mid;
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    // neighbours of the window as it stands after this shift; centre left out
    always_comb
    begin
        q_word.nb[0] = win_reg[0][1];
        q_word.nb[1] = win_reg[0][2];
        q_word.nb[2] = top;
        q_word.nb[3] = win_reg[1][1];
        q_word.nb[4] = mid;
        q_word.nb[5] = win_reg[2][1];
        q_word.nb[6] = win_reg[2][2];
        q_word.nb[7] = s1_pix_reg;
        q_word.row   = s1_row_o_reg;
        q_word.col   = s1_col_o_reg;
        q_word.last  = s1_last_reg;
    end

    assign q_push = s1_valid_reg && s1_emit_reg;

endmodule

`default_nettype wire

// File: src/rgb8m_back.sv
// ----------------------------------------------------------------------------
// rgb8m_back: neighbour sums and result queue
// Sums the eight neighbours per channel, divides by eight and queues results.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb8m_back #(
    parameter int ODEPTH = 2
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rgb8m_pkg::window_word_t q_word,
    input  wire logic                   q_empty,
    output logic                        q_pop,
    output logic                        empty,
    input  wire logic                   pop,
    output rgb8m_pkg::result_t          result
);

    import rgb8m_pkg::*;

    localparam int OCW = $clog2(ODEPTH + 1);

    logic [10:0]    sum_r, sum_g, sum_b;
    result_t        res;
    logic           o_full;
    logic [OCW-1:0] o_count;
    logic [$bits(result_t)-1:0] o_rdata;

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 8; i++)
        begin
            sum_r = sum_r + 11'(q_word.nb[i].red_in);
            sum_g = sum_g + 11'(q_word.nb[i].green_in);
            sum_b = sum_b + 11'(q_word.nb[i].blue_in);
        end
        res.red_out    = sum_r[10:3];
        res.green_out  = sum_g[10:3];
        res.blue_out   = sum_b[10:3];
        res.out_row    = q_word.row;
        res.out_col    = q_word.col;
        res.frame_last = q_word.last;
    end

    assign q_pop = !q_empty && !o_full;

    rgb8m_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (ODEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_pop),
        .wdata (res),
        .pop   (pop),
        .rdata (o_rdata),
        .empty (empty),
        .full  (o_full),
        .count (o_count)
    );

    assign result = result_t'(o_rdata);

    // fill count is not needed here beyond the full flag
    logic unused_count;
    assign unused_count = ^o_count;

endmodule

`default_nettype wire

// File: src/rgb_eight_neighbour_mean_3x3.sv
// ----------------------------------------------------------------------------
// rgb_eight_neighbour_mean_3x3: eight-neighbour mean of an RGB frame
// Raster pixels in, floor(sum of eight neighbours / 8) per channel out for
// every interior pixel, tagged with row, column and a last-of-frame flag.
// ----------------------------------------------------------------------------
// Path: a pixel's result passes the line store read stage, then the word queue
// and then the result queue before it reaches the ports.
// Throughput: one pixel per cycle while full is low, set by the single read and
// write per cycle of the line store RAM.
// Reset: width 640, height 480, position row 0 column 0, window zero, queues
// empty. Line stores are not cleared; no clearing pass, words taken at once.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_eight_neighbour_mean_3x3 #(
    parameter int MAX_WIDTH = rgb8m_pkg::MAX_WIDTH_DEF,
    parameter int QDEPTH    = rgb8m_pkg::QDEPTH_DEF,
    parameter int ODEPTH    = rgb8m_pkg::ODEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              wr_en,
    input  wire logic [rgb8m_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire logic [rgb8m_pkg::CFG_DATA_W-1:0]  wr_data,
    // pixel words
    input  wire logic                              push,
    output logic                                   full,
    input  wire rgb8m_pkg::pixel_t                 pixel,
    // result words
    output logic                                   empty,
    input  wire logic                              pop,
    output rgb8m_pkg::result_t                     result
);

    import rgb8m_pkg::*;

    localparam int QCW = $clog2(QDEPTH + 1);

    cfg_wr_t      cfg;
    logic         q_push, q_pop, q_empty, q_full;
    window_word_t q_word_in;
    logic [$bits(window_word_t)-1:0] q_rdata;
    logic [QCW-1:0] q_count;

    assign cfg.en    = wr_en;
    assign cfg.index = wr_index;
    assign cfg.data  = wr_data;

    // front: position, line stores, window; full already covers queue room
    rgb8m_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .QDEPTH    (QDEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .push    (push),
        .pixel   (pixel),
        .full    (full),
        .q_push  (q_push),
        .q_word  (q_word_in),
        .q_count (q_count)
    );

    // neighbour words between front and back
    rgb8m_fifo #(
        .WIDTH ($bits(window_word_t)),
        .DEPTH (QDEPTH)
    ) u_word_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_word_in),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full),
        .count (q_count)
    );

    // back: sums and result queue
    rgb8m_back #(
        .ODEPTH (ODEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_word  (window_word_t'(q_rdata)),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // front reserves room from the count, so the queue full flag is spare
    logic unused_q_full;
    assign unused_q_full = q_full;

endmodule

`default_nettype wire

// File: src/rgb8m_checker.sv
// ----------------------------------------------------------------------------
// rgb8m_checker: port-level checks
// Watches the top level ports and flags results that cannot be right.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb8m_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              push,
    input wire logic                              full,
    input wire logic                              empty,
    input wire logic                              pop,
    input wire rgb8m_pkg::result_t                result
);

    // a waiting result word holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result word changed while waiting");

    // only interior rows are reported
    a_interior_row: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.out_row != 16'd0)
        else $error("border row reported");

    // back-pressure only builds from pixels taken shortly before
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push, 1) || $past(push, 2))
        else $error("full rose with no recent push");

endmodule

bind rgb_eight_neighbour_mean_3x3 rgb8m_checker u_checker (.*);

`default_nettype wire

// File: verif/tb_rgb_eight_neighbour_mean_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_eight_neighbour_mean_3x3: self-checking bench for the 3x3 mean
// Streams raster frames through the block under a range of frame sizes,
// predicts every interior result from its own line stores and window, and
// checks each popped word field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_rgb_eight_neighbour_mean_3x3;
    import rgb8m_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_W        = MAX_WIDTH_DEF;
    // allow for the pipeline registers and the input queue as well
    localparam int DRAIN_CYCLES = 24;
    localparam int LIMIT_CYCLES = 1500000;
    localparam int RANDOM_ITEMS = 680;
    localparam int QUIET_ITEMS  = 600;   // random words after which idling stops
    localparam int PRINT_CAP    = 40;

    // indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known level
    // ------------------------------------------------------------------------
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data  = '0;
    logic                  push     = 1'b0;
    logic                  full;
    pixel_t                pixel    = '0;
    logic                  empty;
    logic                  pop      = 1'b0;
    result_t               result;

    rgb_eight_neighbour_mean_3x3 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .full     (full),
        .pixel    (pixel),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    pixel_t  pending_pixels[$];    // words waiting for the driver
    result_t expected_means[$];    // predicted results, oldest first
    int      fail_count  = 0;
    int      cycle_count = 0;
    logic    no_idle     = 1'b0;   // set for the closing stretch of the run
    int      push_gap    = 0;
    int      pop_gap     = 0;
    result_t want;

    // predictor copy of the registers, position, line stores and window
    logic [11:0] cfg_width  = WIDTH_RESET;
    logic [15:0] cfg_height = HEIGHT_RESET;
    int unsigned col_pos    = 0;
    int unsigned row_pos    = 0;
    pixel_t      row_above[MAX_W];
    pixel_t      two_above[MAX_W];
    pixel_t      win[3][3] = '{default: '0};   // [row top..bottom][col oldest..newest]

    // ------------------------------------------------------------------------
    // Clock and the one reset at the start
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // cycle guard: a hang anywhere ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // width clamps to 3..MAX_W, height is only raised to 3
    function automatic int unsigned eff_width();
        if (cfg_width < 3)
            return 3;
        if (cfg_width > MAX_W)
            return MAX_W;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height < 3) ? 3 : cfg_height;
    endfunction

    // one accepted word: shift the lines and window, emit for interior pixels
    task automatic smooth_pixel(input pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned sum_r;
        int unsigned sum_g;
        int unsigned sum_b;
        int          wr;
        int          wc;
        pixel_t      top;
        pixel_t      mid;
        result_t     res;
        w = eff_width();
        h = eff_height();
        c = col_pos;
        r = row_pos;
        if (c >= w)
            c = w - 1;

        top          = two_above[c];
        mid          = row_above[c];
        two_above[c] = mid;
        row_above[c] = px;

        for (wr = 0; wr < 3; wr++)
        begin
            win[wr][0] = win[wr][1];
            win[wr][1] = win[wr][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;

        if (r >= 2 && c >= 2)
        begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (wr = 0; wr < 3; wr++)
            begin
                for (wc = 0; wc < 3; wc++)
                begin
                    // centre pixel is left out of the mean
                    if (wr != 1 || wc != 1)
                    begin
                        sum_r += win[wr][wc].red_in;
                        sum_g += win[wr][wc].green_in;
                        sum_b += win[wr][wc].blue_in;
                    end
                end
            end
            res.red_out    = 8'(sum_r >> 3);
            res.green_out  = 8'(sum_g >> 3);
            res.blue_out   = 8'(sum_b >> 3);
            res.out_row    = 16'(r - 1);
            res.out_col    = 11'(c - 1);
            res.frame_last = (r + 1 >= h) && (c + 1 >= w);
            expected_means.push_back(res);
        end

        // raster advance, wrapping at the end of the frame
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    // ------------------------------------------------------------------------
    // Driver: pixel words from the pending queue, with random idle bursts
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                smooth_pixel(pixel);
            // a word that was not taken is held as it is
            if (!push || !full)
            begin
                if (push_gap != 0)
                begin
                    push     <= 1'b0;
                    push_gap <= push_gap - 1;
                end
                else if (!no_idle && $urandom_range(0, 9) == 0)
                begin
                    push     <= 1'b0;
                    push_gap <= $urandom_range(0, 17);
                end
                else if (pending_pixels.size() != 0)
                begin
                    push  <= 1'b1;
                    pixel <= pending_pixels.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: pop with random stall bursts, compare against predictions
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            fail_count++;
            if (fail_count <= PRINT_CAP)
                $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_means.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= PRINT_CAP)
                        $display("%0t: word expected none, actual row %0d col %0d",
                                 $time, result.out_row, result.out_col);
                end
                else
                begin
                    want = expected_means.pop_front();
                    check_field("red_out",    want.red_out,    result.red_out);
                    check_field("green_out",  want.green_out,  result.green_out);
                    check_field("blue_out",   want.blue_out,   result.blue_out);
                    check_field("out_row",    want.out_row,    result.out_row);
                    check_field("out_col",    want.out_col,    result.out_col);
                    check_field("frame_last", want.frame_last, result.frame_last);
                end
            end
            if (pop_gap != 0)
            begin
                pop     <= 1'b0;
                pop_gap <= pop_gap - 1;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                pop     <= 1'b0;
                pop_gap <= $urandom_range(0, 17);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // register write; the predictor follows at the edge that takes it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:
            begin
                cfg_width = val[11:0];
                col_pos   = 0;
                row_pos   = 0;
            end
            CFG_IMAGE_HEIGHT:
            begin
                cfg_height = val;
                col_pos    = 0;
                row_pos    = 0;
            end
            default:
            begin
                // undecoded index: no effect, position kept
            end
        endcase
    endtask

    // block idle: every word sent, every result in, pipeline flushed
    task automatic drain();
        while (pending_pixels.size() != 0 || push || expected_means.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly uniform, now and then a rail value
    function automatic logic [7:0] rand_channel();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_random(input int unsigned count);
        pixel_t      px;
        int unsigned k;
        for (k = 0; k < count; k++)
        begin
            px.red_in   = rand_channel();
            px.green_in = rand_channel();
            px.blue_in  = rand_channel();
            pending_pixels.push_back(px);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        pixel_t      px;
        int unsigned i;
        int unsigned n;
        int unsigned rand_items;
        int unsigned action;
        logic [11:0] wval;
        logic [15:0] hval;

        @(posedge rst_n);

        // reset sizes 640 x 480: the first row gives no results
        queue_random(40);
        drain();
        // narrowest row under the reset height: interior rows, never last
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        queue_random(30);
        drain();

        // smallest frame, 3 x 3: a single interior pixel, flagged last
        write_reg(CFG_IMAGE_HEIGHT, 16'd3);
        // rails on red and green around an opposite centre, small blue ramp
        for (i = 0; i < 9; i++)
        begin
            px.red_in   = (i == 4) ? 8'h00 : 8'hFF;
            px.green_in = (i == 4) ? 8'hFF : 8'h00;
            px.blue_in  = (i == 4) ? 8'd200 : 8'((i < 4) ? i + 1 : i);
            pending_pixels.push_back(px);
        end
        // second frame straight after the wrap: sums that round down
        for (i = 0; i < 9; i++)
        begin
            px.red_in   = (i == 4) ? 8'h00 : ((i == 7) ? 8'hFE : 8'hFF);
            px.green_in = (i == 0) ? 8'd7 : 8'h00;
            px.blue_in  = (i == 4) ? 8'hFF : 8'h80;
            pending_pixels.push_back(px);
        end
        drain();
        // undecoded index mid-frame must leave the position alone
        queue_random(4);
        drain();
        write_reg(CFG_SPARE_2, 16'hFFFF);
        queue_random(5);
        drain();

        // oversized width clamps to the widest row, tallest height; no interior yet
        write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        queue_random(20);
        drain();

        // random phases: mostly small frames, some out of range registers,
        // partial frames and writes that land mid-frame
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (rand_items >= QUIET_ITEMS)
                no_idle <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                wval = 12'($urandom_range(0, 2)) | 12'(($urandom_range(0, 1)) ? 0 : 40);
            else
                wval = 12'($urandom_range(3, 12));
            if ($urandom_range(0, 7) == 0)
                hval = 16'($urandom_range(0, 2));
            else
                hval = 16'($urandom_range(3, 7));
            action = $urandom_range(0, 9);
            case (action)
                0, 1, 2, 3, 4, 5:
                begin
                    // junk above bit 11 is dropped by the width register
                    write_reg(CFG_IMAGE_WIDTH, {4'($urandom_range(0, 15)), wval});
                    write_reg(CFG_IMAGE_HEIGHT, hval);
                end
                6:
                begin
                    write_reg(CFG_IMAGE_WIDTH, {4'($urandom_range(0, 15)), wval});
                end
                7:
                begin
                    write_reg(CFG_IMAGE_HEIGHT, hval);
                end
                8:
                begin
                    write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                              16'($urandom_range(0, 65535)));
                end
                default:
                begin
                    // carry on from the current position
                end
            endcase
            n = $urandom_range(1, 2 * eff_width() * eff_height());
            if (n > 300)
                n = 300;
            if (n > RANDOM_ITEMS - rand_items)
                n = RANDOM_ITEMS - rand_items;
            queue_random(n);
            rand_items += n;
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
